@@ hw/rtl/srpd_pkg.sv @@
package srpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 16;
  localparam int COUNT_W  = 8;

  localparam int HISTORY_DEPTH = 10;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam int SUM_W         = TIME_W + HIST_IDX_W;

  localparam int MEAN_SHIFT = SUM_W + HIST_IDX_W;
  localparam int RECIP_W    = SUM_W + 1;
  localparam int MEAN_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  localparam int GUARD_DIV   = 5;
  localparam int GUARD_MUL   = 3;
  localparam int GUARD_SHIFT = TIME_W + $clog2(GUARD_DIV);
  localparam int GUARD_RECIP_W = TIME_W + 2;
  localparam int GUARD_PROD_W  = TIME_W + GUARD_RECIP_W;
  localparam logic [GUARD_RECIP_W-1:0] GUARD_RECIP =
    GUARD_RECIP_W'(((64'd1 << GUARD_SHIFT) + 64'(GUARD_DIV) - 64'd1) / 64'(GUARD_DIV));

  localparam logic [SAMPLE_W-1:0] BASE_LEVEL_RST    = 12'd2048;
  localparam logic [SAMPLE_W-1:0] INIT_THRESHOLD_RST = 12'd2060;
  localparam logic [SAMPLE_W-1:0] LEVEL_RST         = 12'd2048;
  localparam logic [TIME_W-1:0]   MIN_GAP_RST       = 16'd300;
  localparam logic [TIME_W-1:0]   IDLE_TIMEOUT_RST  = 16'd2500;
  localparam logic [TIME_W-1:0]   DECAY_PERIOD_RST  = 16'd5000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX         = 8'd255;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEVEL        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_PERIOD      = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic                in_response;
    logic                new_response;
    logic [COUNT_W-1:0]  short_count;
    logic [COUNT_W-1:0]  long_count;
    logic [SAMPLE_W-1:0] threshold_level;
    logic [SAMPLE_W-1:0] last_amplitude;
    logic [SAMPLE_W-1:0] last_peak_value;
    logic [TIME_W-1:0]   mean_interval_ms;
  } out_item_t;

  function automatic logic [TIME_W-1:0] guard_of(input logic [TIME_W-1:0] interval);
    logic [GUARD_PROD_W-1:0] prod;
    logic [TIME_W-1:0]       quot;
    prod = GUARD_PROD_W'(interval) * GUARD_PROD_W'(GUARD_RECIP);
    quot = TIME_W'(prod >> GUARD_SHIFT);
    return TIME_W'(quot * TIME_W'(GUARD_MUL));
  endfunction

endpackage

@@ hw/rtl/srpd_if.sv @@
interface srpd_in_if;
  logic               valid;
  logic               ready;
  srpd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srpd_out_if;
  logic                valid;
  logic                ready;
  srpd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srpd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [srpd_pkg::CFG_INDEX_W-1:0]     index;
  logic [srpd_pkg::CFG_DATA_W-1:0]      wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/skin_response_peak_detector.sv @@
// An accepted sample request is registered in the a stage, then in the b output register, where its result appears.
// One sample per cycle while the output is not stalled; the detector state updates in the accept cycle and
// the mean interval is divided out of a running history sum in the second stage.
// Reset (rst, synchronous, active high) loads the register defaults, clears the history
// and both pipeline stages. Configuration writes are always taken; none ever stall.
module skin_response_peak_detector (
  input logic clk,
  input logic rst,
  srpd_in_if.sink    samples,
  srpd_out_if.source results,
  srpd_cfg_if.sink   cfg
);
  import srpd_pkg::*;

  logic [SAMPLE_W-1:0] base_level;
  logic [TIME_W-1:0]   min_gap_ms;
  logic [TIME_W-1:0]   idle_timeout_ms;
  logic [TIME_W-1:0]   decay_period_ms;

  logic [SAMPLE_W-1:0] threshold, threshold_next;
  logic [SAMPLE_W-1:0] peak_level, peak_level_next;
  logic [SAMPLE_W-1:0] trough_level, trough_level_next;
  logic                responding, responding_next;
  logic                first_seen, first_seen_next;
  logic                second_seen, second_seen_next;
  logic [TIME_W-1:0]   last_response_time, last_response_time_next;
  logic [TIME_W-1:0]   guard, guard_next;
  logic [TIME_W-1:0]   history [HISTORY_DEPTH];
  logic [TIME_W-1:0]   history_next [HISTORY_DEPTH];
  logic [SUM_W-1:0]    history_sum, history_sum_next;
  logic [TIME_W-1:0]   decay_time, decay_time_next;
  logic                decay_parity, decay_parity_next;
  logic [COUNT_W-1:0]  short_responses, short_responses_next;
  logic [COUNT_W-1:0]  long_responses, long_responses_next;
  logic [SAMPLE_W-1:0] amplitude, amplitude_next;
  logic [SAMPLE_W-1:0] peak_latch, peak_latch_next;

  logic [SAMPLE_W-1:0] s;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   elapsed;
  logic                started;
  logic                in_accept;

  logic                a_valid;
  out_item_t           a_res;
  out_item_t           a_done;
  logic [SUM_W-1:0]    a_sum;
  logic                b_valid;
  out_item_t           b_res;
  logic                b_load;
  logic [MEAN_PROD_W-1:0] mean_prod;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level      <= BASE_LEVEL_RST;
      min_gap_ms      <= MIN_GAP_RST;
      idle_timeout_ms <= IDLE_TIMEOUT_RST;
      decay_period_ms <= DECAY_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_LEVEL:        base_level <= SAMPLE_W'(cfg.wdata);
        REG_INITIAL_THRESHOLD: ;
        REG_MIN_GAP:           min_gap_ms <= cfg.wdata;
        REG_IDLE_TIMEOUT:      idle_timeout_ms <= cfg.wdata;
        REG_DECAY_PERIOD:      decay_period_ms <= cfg.wdata;
        default:               ;
      endcase
    end
  end

  assign s   = samples.data.sample;
  assign now = samples.data.now_ms;

  always_comb begin
    logic above;
    logic below;
    logic past_guard;
    logic skip_rest;

    elapsed    = now - last_response_time;
    above      = s > threshold;
    below      = s < threshold;
    past_guard = elapsed > guard;

    threshold_next          = threshold;
    trough_level_next       = trough_level;
    responding_next         = responding;
    first_seen_next         = first_seen;
    second_seen_next        = second_seen;
    last_response_time_next = last_response_time;
    guard_next              = guard;
    history_next            = history;
    history_sum_next        = history_sum;
    decay_time_next         = decay_time;
    decay_parity_next       = decay_parity;
    short_responses_next    = short_responses;
    long_responses_next     = long_responses;
    amplitude_next          = amplitude;
    peak_latch_next         = peak_latch;

    if (TIME_W'(now - decay_time) > decay_period_ms) begin
      decay_parity_next = ~decay_parity;
      decay_time_next   = now;
      if (short_responses != '0) begin
        short_responses_next = short_responses - 8'd1;
      end
      if (long_responses > 8'd1 && !decay_parity_next) begin
        long_responses_next = long_responses - 8'd2;
      end
    end

    peak_level_next = (above && s > peak_level) ? s : peak_level;

    if (below && past_guard) begin
      peak_latch_next = peak_level_next;
      if (s < trough_level) begin
        trough_level_next = s;
      end
    end

    started = (elapsed > min_gap_ms) && above && !responding && past_guard;
    skip_rest = started && first_seen;

    if (started) begin
      responding_next         = 1'b1;
      last_response_time_next = now;
      guard_next              = guard_of(elapsed);
      if (short_responses_next != COUNT_MAX) begin
        short_responses_next = short_responses_next + 8'd1;
      end
      if (long_responses_next != COUNT_MAX) begin
        long_responses_next = long_responses_next + 8'd1;
      end
      if (first_seen) begin
        first_seen_next  = 1'b0;
        second_seen_next = 1'b1;
      end else if (second_seen) begin
        second_seen_next = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          history_next[i] = elapsed;
        end
        history_sum_next = SUM_W'(elapsed) * SUM_W'(HISTORY_DEPTH);
      end else begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          history_next[i] = history[i+1];
        end
        history_next[HISTORY_DEPTH-1] = elapsed;
        history_sum_next = history_sum - SUM_W'(history[0]) + SUM_W'(elapsed);
      end
    end

    if (!skip_rest) begin
      if (below && responding) begin
        responding_next   = 1'b0;
        amplitude_next    = peak_level_next - trough_level_next;
        threshold_next    = SAMPLE_W'(amplitude_next >> 1) + trough_level_next;
        peak_level_next   = threshold_next;
        trough_level_next = threshold_next;
      end
      if (elapsed > idle_timeout_ms) begin
        threshold_next          = base_level;
        peak_level_next         = base_level;
        trough_level_next       = base_level;
        last_response_time_next = now;
        first_seen_next         = 1'b1;
        second_seen_next        = 1'b0;
      end
    end
  end

  assign b_load        = !b_valid || results.ready;
  assign samples.ready = !a_valid || b_load;
  assign in_accept     = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold          <= INIT_THRESHOLD_RST;
      peak_level         <= LEVEL_RST;
      trough_level       <= LEVEL_RST;
      responding         <= 1'b0;
      first_seen         <= 1'b1;
      second_seen        <= 1'b0;
      last_response_time <= '0;
      guard              <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
      history_sum        <= '0;
      decay_time         <= '0;
      decay_parity       <= 1'b0;
      short_responses    <= '0;
      long_responses     <= '0;
      amplitude          <= '0;
      peak_latch         <= '0;
    end else if (in_accept) begin
      threshold          <= threshold_next;
      peak_level         <= peak_level_next;
      trough_level       <= trough_level_next;
      responding         <= responding_next;
      first_seen         <= first_seen_next;
      second_seen        <= second_seen_next;
      last_response_time <= last_response_time_next;
      guard              <= guard_next;
      history            <= history_next;
      history_sum        <= history_sum_next;
      decay_time         <= decay_time_next;
      decay_parity       <= decay_parity_next;
      short_responses    <= short_responses_next;
      long_responses     <= long_responses_next;
      amplitude          <= amplitude_next;
      peak_latch         <= peak_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (samples.ready) begin
      a_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_res <= {responding_next, started, short_responses_next, long_responses_next,
                threshold_next, amplitude_next, peak_latch_next, TIME_W'(0)};
      a_sum <= history_sum_next;
    end
  end

  assign mean_prod = MEAN_PROD_W'(a_sum) * MEAN_PROD_W'(MEAN_RECIP);

  always_comb begin
    a_done                  = a_res;
    a_done.mean_interval_ms = TIME_W'(mean_prod >> MEAN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      b_res <= a_done;
    end
  end

  assign results.valid = b_valid;
  assign results.data  = b_res;

  a_new_implies_active: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_res.new_response |-> a_res.in_response)
    else $error("response start without response in progress");

  a_seen_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(first_seen && second_seen))
    else $error("first and second response marks both set");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> a_valid)
    else $error("accepted sample request lost before the output stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_load |=> a_valid && $stable(a_sum))
    else $error("stalled stage changed");

endmodule
